/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset has been released
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds once reset has been released
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (!(cond))) else $error(msg);

`endif

/* sv/fpr_pkg.sv */
package fpr_pkg;

  // Fixed field widths
  localparam int unsigned PageInW   = 5;
  localparam int unsigned FrameOutW = 5;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CfgW      = 6;

  localparam logic [CountW-1:0] CounterMax    = 16'hFFFF;
  localparam logic [CfgW-1:0]   FrameCountRst = 6'd4;

  // Parameter defaults
  localparam int unsigned VirtualPagesDef = 32;
  localparam int unsigned MaxFramesDef    = 32;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_step;
    logic lookup;
    logic decide;
    logic evict;
    logic commit;
    logic load_out;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic pt_hit;
    logic need_evict;
  } stat_t;

endpackage

/* sv/fifo_page_replacement_top.sv */
// Channel  Dir  Handshake                Payload
// in       in   in_valid_i/in_ready_o    in_command_i, in_page_i
// out      out  out_valid_o/out_ready_i  hit, frame, evicted_valid, evicted_page, fault_count
// cfg      in   cfg_we_i                 cfg_wdata_i (frame count)
//
// One transaction at a time: a hit steps through lookup, decide and finish before the next
// acceptance, a fault adds commit and an eviction adds evict; the registered table reads,
// the victim invalidate and the page load each take a step of their own.
// A clear command sweeps the page table; after reset the same sweep holds in_ready_o low.
// A stalled output holds only the final step of the next transaction.
module fifo_page_replacement_top #(
  parameter int unsigned VIRTUAL_PAGES = fpr_pkg::VirtualPagesDef,
  parameter int unsigned MAX_FRAMES    = fpr_pkg::MaxFramesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fpr_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_command_i,
  input  logic [fpr_pkg::PageInW-1:0]   in_page_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_hit_o,
  output logic [fpr_pkg::FrameOutW-1:0] out_frame_o,
  output logic                          out_evicted_valid_o,
  output logic [fpr_pkg::FrameOutW-1:0] out_evicted_page_o,
  output logic [fpr_pkg::CountW-1:0]    out_fault_count_o
);

  fpr_pkg::ctrl_t ctrl;
  fpr_pkg::stat_t stat;

  fpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_command_i(in_command_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  fpr_datapath #(
    .VIRTUAL_PAGES(VIRTUAL_PAGES),
    .MAX_FRAMES   (MAX_FRAMES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_page_i          (in_page_i),
    .ctrl_i             (ctrl),
    .stat_o             (stat),
    .out_hit_o          (out_hit_o),
    .out_frame_o        (out_frame_o),
    .out_evicted_valid_o(out_evicted_valid_o),
    .out_evicted_page_o (out_evicted_page_o),
    .out_fault_count_o  (out_fault_count_o)
  );

endmodule

/* sv/fpr_ram.sv */
module fpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fpr_ctrl.sv */
`include "assert_macros.svh"

module fpr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_command_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fpr_pkg::stat_t stat_i,
  output fpr_pkg::ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StLookup,
    StDecide,
    StEvict,
    StCommit,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   from_cmd_q, from_cmd_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load_out;

  // Decode commands from the current state
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_ready_o & in_valid_i;
  assign load_out   = (state_q == StFinish) & (~out_valid_q | out_ready_i);

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.accept    = accept;
    ctrl_o.clr_start = accept & in_command_i;
    ctrl_o.clr_step  = (state_q == StClear);
    ctrl_o.lookup    = (state_q == StLookup);
    ctrl_o.decide    = (state_q == StDecide);
    ctrl_o.evict     = (state_q == StEvict);
    ctrl_o.commit    = (state_q == StCommit);
    ctrl_o.load_out  = load_out;
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    from_cmd_d = from_cmd_q;
    case (state_q)
      StClear: begin
        if (stat_i.clr_last) begin
          state_d = from_cmd_q ? StFinish : StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          from_cmd_d = in_command_i;
          state_d    = in_command_i ? StClear : StLookup;
        end
      end
      StLookup: state_d = StDecide;
      StDecide: begin
        if (stat_i.pt_hit) begin
          state_d = StFinish;
        end else if (stat_i.need_evict) begin
          state_d = StEvict;
        end else begin
          state_d = StCommit;
        end
      end
      StEvict:  state_d = StCommit;
      StCommit: state_d = StFinish;
      StFinish: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold the result slot until the transaction is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Sweep the page table straight after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      from_cmd_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      from_cmd_q  <= from_cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_AT(a_one_item, clk_i, rst_ni, accept |=> !in_ready_o, "second item taken while busy")
  `ASSERT_AT(a_result_from_finish, clk_i, rst_ni,
             $rose(out_valid_o) |-> $past(state_q == StFinish), "result raised outside finish")

endmodule

/* sv/fpr_datapath.sv */
`include "assert_macros.svh"

module fpr_datapath #(
  parameter int unsigned VIRTUAL_PAGES = fpr_pkg::VirtualPagesDef,
  parameter int unsigned MAX_FRAMES    = fpr_pkg::MaxFramesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fpr_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic [fpr_pkg::PageInW-1:0]      in_page_i,
  input  fpr_pkg::ctrl_t                   ctrl_i,
  output fpr_pkg::stat_t                   stat_o,
  output logic                             out_hit_o,
  output logic [fpr_pkg::FrameOutW-1:0]    out_frame_o,
  output logic                             out_evicted_valid_o,
  output logic [fpr_pkg::FrameOutW-1:0]    out_evicted_page_o,
  output logic [fpr_pkg::CountW-1:0]       out_fault_count_o
);

  localparam int unsigned PageW   = $clog2(VIRTUAL_PAGES);
  localparam int unsigned FrameW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned FillW   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CmpW    = (fpr_pkg::CfgW > FillW) ? fpr_pkg::CfgW : FillW;
  localparam int unsigned FrmXW   = FrameW + fpr_pkg::FrameOutW;
  localparam int unsigned PgXW    = PageW + fpr_pkg::FrameOutW;
  localparam int unsigned PtW     = FrameW + 1;
  localparam int unsigned InPages = 2 ** fpr_pkg::PageInW;
  localparam logic [PageW-1:0] LastPage = PageW'(VIRTUAL_PAGES - 1);

  logic [fpr_pkg::CfgW-1:0]   frame_count_q;
  logic [PageW-1:0]           pg_q;
  logic [PageW-1:0]           sweep_q;
  logic [FillW-1:0]           filled_q;
  logic [FrameW-1:0]          oldest_q;
  logic [fpr_pkg::CountW-1:0] fault_q;
  logic [FrameW-1:0]          frm_q;
  logic                       res_hit_q;
  logic                       res_ev_valid_q;
  logic [PageW-1:0]           res_ev_page_q;

  logic [PageW-1:0]  pg_mod [InPages];
  logic [CmpW-1:0]   cfg_x;
  logic [CmpW-1:0]   fc_x;
  logic [FillW-1:0]  fc;
  logic              need_evict;
  logic [FrameW-1:0] oldest_eff;
  logic [FillW-1:0]  oldest_inc;
  logic [FrameW-1:0] oldest_nxt;
  logic [FrmXW-1:0]  frm_x;
  logic [PgXW-1:0]   ev_x;

  logic              pt_we;
  logic [PageW-1:0]  pt_waddr;
  logic [PtW-1:0]    pt_wdata;
  logic [PtW-1:0]    pt_rdata;
  logic [PageW-1:0]  own_rdata;

  // Fold the page number into the virtual space
  for (genvar g = 0; g < InPages; g++) begin : g_mod
    assign pg_mod[g] = PageW'(g % VIRTUAL_PAGES);
  end

  // Clamp the frame count to 1 .. MAX_FRAMES
  assign cfg_x = CmpW'(frame_count_q);
  assign fc_x  = (cfg_x == '0) ? CmpW'(1) :
                 (cfg_x > CmpW'(MAX_FRAMES)) ? CmpW'(MAX_FRAMES) : cfg_x;
  assign fc    = fc_x[FillW-1:0];

  assign need_evict = (filled_q >= fc);

  // Wrap the oldest frame after the count has been lowered
  assign oldest_eff = (FillW'(oldest_q) >= fc) ? '0 : oldest_q;
  assign oldest_inc = FillW'(oldest_eff) + FillW'(1);
  assign oldest_nxt = (oldest_inc >= fc) ? '0 : oldest_inc[FrameW-1:0];

  // Page table write port: sweep, invalidate victim, or load page
  always_comb begin
    pt_we    = ctrl_i.clr_step | ctrl_i.evict | ctrl_i.commit;
    pt_waddr = pg_q;
    pt_wdata = {1'b1, frm_q};
    if (ctrl_i.clr_step) begin
      pt_waddr = sweep_q;
      pt_wdata = '0;
    end else if (ctrl_i.evict) begin
      pt_waddr = own_rdata;
      pt_wdata = '0;
    end
  end

  fpr_ram #(
    .WIDTH(PtW),
    .DEPTH(VIRTUAL_PAGES)
  ) u_page_table (
    .clk_i  (clk_i),
    .we_i   (pt_we),
    .waddr_i(pt_waddr),
    .wdata_i(pt_wdata),
    .re_i   (ctrl_i.lookup),
    .raddr_i(pg_q),
    .rdata_o(pt_rdata)
  );

  fpr_ram #(
    .WIDTH(PageW),
    .DEPTH(MAX_FRAMES)
  ) u_frame_owner (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.commit),
    .waddr_i(frm_q),
    .wdata_i(pg_q),
    .re_i   (ctrl_i.decide),
    .raddr_i(oldest_eff),
    .rdata_o(own_rdata)
  );

  assign stat_o.clr_last   = (sweep_q == LastPage);
  assign stat_o.pt_hit     = pt_rdata[FrameW];
  assign stat_o.need_evict = need_evict;

  // Configuration, frame pointers and fault counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= fpr_pkg::FrameCountRst;
      sweep_q       <= '0;
      filled_q      <= '0;
      oldest_q      <= '0;
      fault_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= cfg_wdata_i;
      end
      if (ctrl_i.clr_start) begin
        sweep_q  <= '0;
        filled_q <= '0;
        oldest_q <= '0;
        fault_q  <= '0;
      end else if (ctrl_i.clr_step) begin
        sweep_q <= sweep_q + PageW'(1);
      end else if (ctrl_i.decide && !pt_rdata[FrameW]) begin
        if (fault_q != fpr_pkg::CounterMax) begin
          fault_q <= fault_q + fpr_pkg::CountW'(1);
        end
        if (need_evict) begin
          oldest_q <= oldest_nxt;
        end else begin
          filled_q <= filled_q + FillW'(1);
        end
      end
    end
  end

  // Latch the transaction and build its result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      pg_q <= pg_mod[in_page_i];
    end
    if (ctrl_i.clr_start) begin
      res_hit_q      <= 1'b0;
      frm_q          <= '0;
      res_ev_valid_q <= 1'b0;
      res_ev_page_q  <= '0;
    end else if (ctrl_i.decide) begin
      res_hit_q      <= pt_rdata[FrameW];
      res_ev_valid_q <= 1'b0;
      res_ev_page_q  <= '0;
      if (pt_rdata[FrameW]) begin
        frm_q <= pt_rdata[FrameW-1:0];
      end else if (need_evict) begin
        frm_q <= oldest_eff;
      end else begin
        frm_q <= filled_q[FrameW-1:0];
      end
    end else if (ctrl_i.evict) begin
      res_ev_valid_q <= 1'b1;
      res_ev_page_q  <= own_rdata;
    end
  end

  assign frm_x = FrmXW'(frm_q);
  assign ev_x  = PgXW'(res_ev_page_q);

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_hit_o           <= res_hit_q;
      out_frame_o         <= frm_x[fpr_pkg::FrameOutW-1:0];
      out_evicted_valid_o <= res_ev_valid_q;
      out_evicted_page_o  <= ev_x[fpr_pkg::FrameOutW-1:0];
      out_fault_count_o   <= fault_q;
    end
  end

  `ASSERT_AT(a_fault_monotonic, clk_i, rst_ni,
             !$past(ctrl_i.clr_start) |-> (fault_q >= $past(fault_q)),
             "fault counter dropped without clear")
  `ASSERT_NEVER(a_filled_bound, clk_i, rst_ni, filled_q > FillW'(MAX_FRAMES),
                "more frames filled than exist")

endmodule

/* tb/tb_fifo_page_replacement_top.sv */
module tb_fifo_page_replacement_top;

  localparam int unsigned VirtualPages = fpr_pkg::VirtualPagesDef;
  localparam int unsigned MaxFrames    = fpr_pkg::MaxFramesDef;
  localparam int unsigned PageW        = fpr_pkg::PageInW;
  localparam int unsigned FrameW       = fpr_pkg::FrameOutW;
  localparam int unsigned CountW       = fpr_pkg::CountW;
  localparam int unsigned CfgW         = fpr_pkg::CfgW;

  // Command codes on in_command_i
  localparam logic CmdRef   = 1'b0;
  localparam logic CmdClear = 1'b1;

  localparam int SettleCycles  = 8;
  localparam int HoldOffCycles = 300;
  localparam int PhaseRefs     = 110;
  localparam int TailRefs      = 60;
  localparam int FaultRefs     = 20;
  localparam int PrintCap      = 100;

  typedef struct packed {
    logic             command;
    logic [PageW-1:0] page;
  } page_req_t;

  typedef struct packed {
    logic              hit;
    logic [FrameW-1:0] frame;
    logic              ev_valid;
    logic [FrameW-1:0] ev_page;
    logic [CountW-1:0] faults;
  } xlate_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              in_command_i = CmdRef;
  logic [PageW-1:0]  in_page_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              out_hit_o;
  logic [FrameW-1:0] out_frame_o;
  logic              out_evicted_valid_o;
  logic [FrameW-1:0] out_evicted_page_o;
  logic [CountW-1:0] out_fault_count_o;

  // Predicted state of the page table and the frame allocator
  bit                pt_valid [VirtualPages];
  logic [FrameW-1:0] pt_frame [VirtualPages];
  logic [PageW-1:0]  frame_owner [MaxFrames];
  int                frames_used = 0;
  int                oldest = 0;
  logic [CountW-1:0] fault_tally = '0;
  logic [CfgW-1:0]   frames_setting = fpr_pkg::FrameCountRst;

  page_req_t pending_refs [$];
  xlate_t    awaited_xlates [$];

  int mismatches = 0;
  int checked = 0;
  int idle_odds = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_cnt = 0;
  int hold_req = 0;
  int hold_ack = 0;

  int frame_settings [13] = '{1, 2, 3, 5, 8, 16, 31, 32, 33, 63, 0, 7, 4};
  int odds_choices [4] = '{0, 3, 6, 12};

  fifo_page_replacement_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_command_i       (in_command_i),
    .in_page_i          (in_page_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_hit_o          (out_hit_o),
    .out_frame_o        (out_frame_o),
    .out_evicted_valid_o(out_evicted_valid_o),
    .out_evicted_page_o (out_evicted_page_o),
    .out_fault_count_o  (out_fault_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Clamp the frame count to the range the allocator honours
  function automatic int usable_frames(input logic [CfgW-1:0] setting);
    int n;
    n = int'(setting);
    if (n < 1) n = 1;
    if (n > MaxFrames) n = MaxFrames;
    return n;
  endfunction

  // Translate one reference and queue the result it must produce
  function automatic void model_reference(input logic cmd, input logic [PageW-1:0] pg);
    xlate_t r;
    int     eff;
    int     victim;
    r = '0;
    if (cmd == CmdClear) begin
      foreach (pt_valid[i]) pt_valid[i] = 1'b0;
      frames_used = 0;
      oldest      = 0;
      fault_tally = '0;
    end else if (pt_valid[pg]) begin
      r.hit   = 1'b1;
      r.frame = pt_frame[pg];
    end else begin
      eff = usable_frames(frames_setting);
      if (fault_tally != fpr_pkg::CounterMax) fault_tally = fault_tally + CountW'(1);
      if (frames_used < eff) begin
        r.frame     = FrameW'(frames_used);
        frames_used = frames_used + 1;
      end else begin
        // Reclaim the oldest frame below the current count
        if (oldest >= eff) oldest = 0;
        r.frame          = FrameW'(oldest);
        victim           = int'(frame_owner[r.frame]);
        pt_valid[victim] = 1'b0;
        r.ev_valid       = 1'b1;
        r.ev_page        = FrameW'(victim);
        oldest           = (oldest + 1 >= eff) ? 0 : oldest + 1;
      end
      frame_owner[r.frame] = pg;
      pt_valid[pg]         = 1'b1;
      pt_frame[pg]         = r.frame;
    end
    r.faults = fault_tally;
    awaited_xlates.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintCap) $display("mismatch at result %0d: %s", checked, what);
  endtask

  // Drive the input channel from the pending queue, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    page_req_t nxt;
    logic      take;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      in_command_i <= CmdRef;
      in_page_i    <= '0;
      src_gap = 0;
    end else begin
      take = in_valid_i && in_ready_o;
      if (take) model_reference(in_command_i, in_page_i);
      if (!in_valid_i || take) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          src_gap = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else if (pending_refs.size() != 0) begin
          nxt = pending_refs.pop_front();
          in_valid_i   <= 1'b1;
          in_command_i <= nxt.command;
          in_page_i    <= nxt.page;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Drive out_ready_i: random stalls plus the occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin : sink_proc
    logic nxt_ready;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap = 0;
      hold_cnt = 0;
    end else begin
      nxt_ready = 1'b0;
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_cnt = HoldOffCycles - 1;
      end else if (sink_gap > 0) begin
        sink_gap--;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        sink_gap = $urandom_range(0, 10);
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready_i <= nxt_ready;
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin : check_proc
    xlate_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      checked++;
      if (awaited_xlates.size() == 0) begin
        flag_mismatch("result arrived with nothing awaited");
      end else begin
        want = awaited_xlates.pop_front();
        if (out_hit_o !== want.hit)
          flag_mismatch($sformatf("hit %0b, want %0b", out_hit_o, want.hit));
        if (out_frame_o !== want.frame)
          flag_mismatch($sformatf("frame %0d, want %0d", out_frame_o, want.frame));
        if (out_evicted_valid_o !== want.ev_valid)
          flag_mismatch($sformatf("evicted_valid %0b, want %0b",
                                  out_evicted_valid_o, want.ev_valid));
        if (out_evicted_page_o !== want.ev_page)
          flag_mismatch($sformatf("evicted_page %0d, want %0d",
                                  out_evicted_page_o, want.ev_page));
        if (out_fault_count_o !== want.faults)
          flag_mismatch($sformatf("fault_count %0d, want %0d",
                                  out_fault_count_o, want.faults));
      end
    end
  end

  task automatic queue_ref(input logic cmd, input int pg);
    page_req_t r;
    r.command = cmd;
    r.page    = PageW'(pg);
    pending_refs.push_back(r);
  endtask

  // Hold the sender until every awaited result has come back
  task automatic drain_all();
    do @(negedge clk_i);
    while (pending_refs.size() != 0 || in_valid_i || awaited_xlates.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_frames(input int setting);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CfgW'(setting);
    frames_setting = CfgW'(setting);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly references within a working set a little larger than the frame pool
  task automatic queue_random(input int count);
    int span;
    int pg;
    span = usable_frames(frames_setting) + 2;
    if (span > VirtualPages - 1) span = VirtualPages - 1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) pg = $urandom_range(0, VirtualPages - 1);
      else pg = $urandom_range(0, span);
      queue_ref(($urandom_range(0, 39) == 0) ? CmdClear : CmdRef, pg);
    end
  endtask

  initial begin : stimulus
    int prev_pg;
    int pg;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the reset pool of four frames, hit, then evict in frame order
    queue_ref(CmdRef, 0);
    queue_ref(CmdRef, 1);
    queue_ref(CmdRef, 2);
    queue_ref(CmdRef, 3);
    queue_ref(CmdRef, 0);
    queue_ref(CmdRef, 4);
    queue_ref(CmdRef, 31);
    queue_ref(CmdRef, 1);
    drain_all();

    // Lower the count: pages in frames above it still hit, oldest frame wraps to 0
    write_frames(2);
    queue_ref(CmdRef, 3);
    queue_ref(CmdRef, 1);
    queue_ref(CmdRef, 9);
    queue_ref(CmdRef, 4);
    drain_all();

    // Count of zero acts as one; clear ignores its page field
    write_frames(0);
    queue_ref(CmdRef, 10);
    queue_ref(CmdRef, 3);
    queue_ref(CmdClear, 31);
    queue_ref(CmdRef, 31);
    drain_all();

    // Count above the frame limit
    write_frames(63);
    queue_ref(CmdRef, 0);
    queue_ref(CmdRef, 31);
    queue_ref(CmdRef, 21);
    queue_ref(CmdRef, 10);
    drain_all();

    // Random phases over a spread of frame counts and idling rates
    foreach (frame_settings[p]) begin
      write_frames(frame_settings[p]);
      idle_odds = odds_choices[p % 4];
      queue_random(PhaseRefs / 2);
      if (frame_settings[p] == 8) hold_req++;
      if (p == 5) drain_all();
      queue_random(PhaseRefs - PhaseRefs / 2);
      drain_all();
    end

    // No idling from here on; one frame, so every reference faults and all but the first evict
    idle_odds = 0;
    write_frames(1);
    queue_ref(CmdClear, $urandom_range(0, VirtualPages - 1));
    prev_pg = 0;
    for (int i = 0; i < FaultRefs; i++) begin
      do pg = $urandom_range(0, VirtualPages - 1);
      while (pg == prev_pg);
      queue_ref(CmdRef, pg);
      prev_pg = pg;
    end
    queue_ref(CmdClear, $urandom_range(0, VirtualPages - 1));
    drain_all();

    for (int t = 0; t < 2; t++) begin
      write_frames($urandom_range(0, 63));
      queue_random(TailRefs);
      drain_all();
    end

    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // Abort a run that stalls
  initial begin : watchdog
    #(64'd8 * 64'd4_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
